>>> hw/rtl/assert_macros.svh
// Assertion helper macros for the USB-MIDI encoder RTL.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/usbmidi_pkg.sv
// Types and constants for the USB-MIDI event packet encoder.
// No dependencies; used by usb_midi_packet_encoder_top.
`timescale 1ns / 1ps

package usbmidi_pkg;

  typedef struct packed {
    logic       kind;
    logic [3:0] cable;
    logic [7:0] status;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic [6:0] sysex_byte;
    logic       sysex_last;
  } in_item_t;

  typedef struct packed {
    logic [3:0] cable_out;
    logic [3:0] code_index;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic       packet_last;
  } out_item_t;

  localparam logic KIND_SHORT = 1'b0;

  // Code index numbers.
  localparam logic [3:0] CIN_SYS_TWO   = 4'h2;
  localparam logic [3:0] CIN_SYS_THREE = 4'h3;
  localparam logic [3:0] CIN_SX_CONT   = 4'h4;
  localparam logic [3:0] CIN_SX_END1   = 4'h5;
  localparam logic [3:0] CIN_SX_END2   = 4'h6;
  localparam logic [3:0] CIN_SX_END3   = 4'h7;
  localparam logic [3:0] CIN_SINGLE    = 4'hF;

  // Status bytes.
  localparam logic [7:0] SX_START    = 8'hF0;
  localparam logic [7:0] SX_STOP     = 8'hF7;
  localparam logic [7:0] ST_MTC_QF   = 8'hF1;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_TUNE_REQ = 8'hF6;

  // Upper nibbles of channel messages.
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_POLY_AT  = 4'hA;
  localparam logic [3:0] HI_CTRL     = 4'hB;
  localparam logic [3:0] HI_PROG     = 4'hC;
  localparam logic [3:0] HI_CHAN_AT  = 4'hD;
  localparam logic [3:0] HI_BEND     = 4'hE;
  localparam logic [3:0] HI_SYSTEM   = 4'hF;

endpackage

>>> hw/rtl/usb_midi_packet_encoder_top.sv
// USB-MIDI event packet encoder: short messages and SysEx bytes to 4-byte packets.
// Depends on usbmidi_pkg and assert_macros.svh.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall  | usbmidi_pkg::in_item_t
//   out_    | output    | out_valid/out_stall| usbmidi_pkg::out_item_t
//
// One item is taken per cycle unless the input stalls; its packet, if any, appears
// in the output register on the next cycle. A final SysEx byte that closes a full
// group gives two packets, and the second is held in a one-entry overflow register;
// the input stalls while that register is full or while out_stall holds the output
// register. Reset is synchronous and clears the framing state and both valid flags.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module usb_midi_packet_encoder_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  usbmidi_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output usbmidi_pkg::out_item_t out_data
);
  import usbmidi_pkg::*;

  // Framing state.
  logic [7:0] pend0_r, pend0_nxt;
  logic [7:0] pend1_r, pend1_nxt;
  logic [1:0] pend_cnt_r, pend_cnt_nxt;
  logic       in_sysex_r, in_sysex_nxt;

  // Output register and overflow entry.
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       extra_valid_r, extra_valid_nxt;
  out_item_t  extra_r, extra_nxt;

  logic       accept;
  logic [1:0] pkt_num;
  out_item_t  pkt0, pkt1;
  out_item_t  short_pkt;

  logic [7:0] sx_byte;
  logic [7:0] base0;
  logic [1:0] base_n;
  logic [1:0] grp_n;
  logic [7:0] g0, g1, g2;

  assign in_stall  = extra_valid_r || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Short message decode.
  always_comb begin
    short_pkt.cable_out   = in_data.cable;
    short_pkt.code_index  = CIN_SINGLE;
    short_pkt.byte_one    = in_data.status;
    short_pkt.byte_two    = 8'h00;
    short_pkt.byte_three  = 8'h00;
    short_pkt.packet_last = 1'b1;
    unique case (in_data.status[7:4])
      HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CTRL, HI_BEND: begin
        short_pkt.code_index = in_data.status[7:4];
        short_pkt.byte_two   = {1'b0, in_data.data_one};
        short_pkt.byte_three = {1'b0, in_data.data_two};
      end
      HI_PROG, HI_CHAN_AT: begin
        short_pkt.code_index = in_data.status[7:4];
        short_pkt.byte_two   = {1'b0, in_data.data_one};
      end
      HI_SYSTEM: begin
        unique case (in_data.status)
          ST_MTC_QF, ST_SONG_SEL: begin
            short_pkt.code_index = CIN_SYS_TWO;
            short_pkt.byte_two   = {1'b0, in_data.data_one};
          end
          ST_SONG_POS: begin
            short_pkt.code_index = CIN_SYS_THREE;
            short_pkt.byte_two   = {1'b0, in_data.data_one};
            short_pkt.byte_three = {1'b0, in_data.data_two};
          end
          ST_TUNE_REQ: short_pkt.code_index = CIN_SX_END1;
          default:     short_pkt.code_index = CIN_SINGLE;
        endcase
      end
      default: short_pkt.code_index = CIN_SINGLE;
    endcase
  end

  // SysEx group formation: a new stream starts with the start marker in front.
  always_comb begin
    sx_byte = {1'b0, in_data.sysex_byte};
    base0   = in_sysex_r ? pend0_r : SX_START;
    if (!in_sysex_r) begin
      base_n = 2'd1;
    end else if (pend_cnt_r == 2'd3) begin
      base_n = 2'd2;
    end else begin
      base_n = pend_cnt_r;
    end
    grp_n = base_n + 2'd1;
    g0 = 8'h00;
    g1 = 8'h00;
    g2 = 8'h00;
    unique case (base_n)
      2'd0: g0 = sx_byte;
      2'd1: begin
        g0 = base0;
        g1 = sx_byte;
      end
      default: begin
        g0 = base0;
        g1 = pend1_r;
        g2 = sx_byte;
      end
    endcase
  end

  // Packets caused by the current input item, and the framing state update.
  always_comb begin
    pkt0         = short_pkt;
    pkt1.cable_out   = in_data.cable;
    pkt1.code_index  = CIN_SX_END1;
    pkt1.byte_one    = SX_STOP;
    pkt1.byte_two    = 8'h00;
    pkt1.byte_three  = 8'h00;
    pkt1.packet_last = 1'b1;
    pkt_num      = 2'd1;
    pend0_nxt    = pend0_r;
    pend1_nxt    = pend1_r;
    pend_cnt_nxt = pend_cnt_r;
    in_sysex_nxt = in_sysex_r;

    if (in_data.kind != KIND_SHORT) begin
      pkt0.cable_out   = in_data.cable;
      pkt0.packet_last = 1'b1;
      if (in_data.sysex_last) begin
        in_sysex_nxt = 1'b0;
        pend_cnt_nxt = 2'd0;
        priority case (grp_n)
          2'd3: begin
            pkt0.code_index  = CIN_SX_CONT;
            pkt0.byte_one    = g0;
            pkt0.byte_two    = g1;
            pkt0.byte_three  = g2;
            pkt0.packet_last = 1'b0;
            pkt_num          = 2'd2;
          end
          2'd2: begin
            pkt0.code_index = CIN_SX_END3;
            pkt0.byte_one   = g0;
            pkt0.byte_two   = g1;
            pkt0.byte_three = SX_STOP;
          end
          default: begin
            pkt0.code_index = CIN_SX_END2;
            pkt0.byte_one   = g0;
            pkt0.byte_two   = SX_STOP;
            pkt0.byte_three = 8'h00;
          end
        endcase
      end else begin
        in_sysex_nxt = 1'b1;
        pkt0.code_index = CIN_SX_CONT;
        pkt0.byte_one   = g0;
        pkt0.byte_two   = g1;
        pkt0.byte_three = g2;
        if (grp_n == 2'd3) begin
          pend_cnt_nxt = 2'd0;
        end else begin
          // The group is not full yet, so it is held back until more bytes arrive.
          pkt_num      = 2'd0;
          pend0_nxt    = g0;
          if (grp_n == 2'd2) begin
            pend1_nxt = g1;
          end
          pend_cnt_nxt = grp_n;
        end
      end
    end
  end

  // Output register and overflow entry.
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    extra_valid_nxt = extra_valid_r;
    extra_nxt       = extra_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = extra_valid_r;
      out_data_nxt  = extra_r;
      extra_valid_nxt = 1'b0;
    end
    if (accept && pkt_num != 2'd0) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = pkt0;
      if (pkt_num == 2'd2) begin
        extra_valid_nxt = 1'b1;
        extra_nxt       = pkt1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r    <= 2'd0;
      in_sysex_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      extra_valid_r <= 1'b0;
    end else begin
      out_valid_r   <= out_valid_nxt;
      extra_valid_r <= extra_valid_nxt;
      if (accept) begin
        pend_cnt_r <= pend_cnt_nxt;
        in_sysex_r <= in_sysex_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    extra_r    <= extra_nxt;
    if (accept) begin
      pend0_r <= pend0_nxt;
      pend1_r <= pend1_nxt;
    end
  end

  `ASSERT_IMP(a_extra_behind_out, extra_valid_r, out_valid_r,
              "overflow packet held without a packet in the output register")
  `ASSERT_IMP(a_extra_is_end, extra_valid_r,
              extra_r.code_index == CIN_SX_END1 && extra_r.byte_one == SX_STOP,
              "overflow packet is not a lone end marker")
  `ASSERT_IMP(a_cnt_range, 1'b1, pend_cnt_r != 2'd3,
              "pending byte count out of range")
  `ASSERT_NEXT(a_two_pkt, accept && pkt_num == 2'd2, extra_valid_r && out_valid_r,
               "second end packet was not queued")
  `ASSERT_IMP(a_no_accept_on_extra, extra_valid_r, !accept,
              "item transferred while the overflow packet is pending")

endmodule
